[hdl/ffpa_pkg.sv]
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared constants and types of the first-fit pool allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int UNIT_BYTES   = 64;
    localparam int UNIT_SHIFT   = $clog2(UNIT_BYTES);
    localparam int POOL_UNITS   = 1024;
    localparam int UNIT_AW      = $clog2(POOL_UNITS);
    localparam int UNIT_W       = UNIT_AW + 1;
    localparam int CACHE_DEPTH  = 8;
    localparam int CACHE_CW     = $clog2(CACHE_DEPTH + 1);
    localparam int CACHE_IW     = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int HDR_BYTES    = 16;
    localparam int CFG_W        = 17;
    localparam logic [UNIT_W-1:0] NIL_UNIT = UNIT_W'(POOL_UNITS);

    // command codes
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_GET   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [1:0] ST_INVALID   = 2'd3;

    // one unit's entry in the block store
    typedef struct packed {
        logic              hdr;
        logic              alloc;
        logic [UNIT_W-1:0] units;
        logic [UNIT_W-1:0] nxt;
    } mem_word_t;

    // cache control from the sequencer
    typedef struct packed {
        logic               clear;
        logic               take;
        logic               put;
        logic [UNIT_W-1:0]  need;
        logic [UNIT_AW-1:0] unit;
        logic [UNIT_W-1:0]  size;
    } cache_ctrl_t;

    // cache status to the sequencer
    typedef struct packed {
        logic               hit;
        logic [UNIT_AW-1:0] hit_unit;
        logic               full;
    } cache_stat_t;

endpackage

[hdl/ffpa_ram.sv]
// ----------------------------------------------------------------------------
// ffpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/ffpa_cache.sv]
// ----------------------------------------------------------------------------
// ffpa_cache
// LIFO cache of recently freed blocks with first-fit take and compaction.
// ----------------------------------------------------------------------------
module ffpa_cache
    import ffpa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cache_ctrl_t ctrl,
    output cache_stat_t stat
);

    logic [UNIT_AW-1:0]  unit_reg [CACHE_DEPTH];
    logic [UNIT_W-1:0]   size_reg [CACHE_DEPTH];
    logic [CACHE_CW-1:0] count_reg;
    logic [CACHE_DEPTH-1:0] match;
    logic [CACHE_IW-1:0] hit_idx;

    // match entries below the fill count that are large enough
    always_comb begin
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            match[i] = (CACHE_CW'(i) < count_reg) && (size_reg[i] >= ctrl.need);
        end
    end

    // pick the entry nearest the top
    always_comb begin
        hit_idx = '0;
        for (int i = CACHE_DEPTH - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = CACHE_IW'(i);
            end
        end
    end

    assign stat.hit      = |match;
    assign stat.hit_unit = unit_reg[hit_idx];
    assign stat.full     = (count_reg >= CACHE_CW'(CACHE_DEPTH));

    // fill count
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            count_reg <= '0;
        end else if (ctrl.take) begin
            count_reg <= count_reg - CACHE_CW'(1);
        end else if (ctrl.put) begin
            count_reg <= count_reg + CACHE_CW'(1);
        end
    end

    // compact on take, push on put
    always_ff @(posedge aclk) begin
        if (ctrl.take) begin
            for (int j = 0; j < CACHE_DEPTH; j++) begin
                if (CACHE_IW'(j) >= hit_idx) begin
                    if (j == CACHE_DEPTH - 1) begin
                        unit_reg[j] <= '0;
                        size_reg[j] <= '0;
                    end else begin
                        unit_reg[j] <= unit_reg[(j + 1) % CACHE_DEPTH];
                        size_reg[j] <= size_reg[(j + 1) % CACHE_DEPTH];
                    end
                end
            end
        end else if (ctrl.put) begin
            for (int j = CACHE_DEPTH - 1; j > 0; j--) begin
                unit_reg[j] <= unit_reg[j - 1];
                size_reg[j] <= size_reg[j - 1];
            end
            unit_reg[0] <= ctrl.unit;
            size_reg[0] <= ctrl.size;
        end
    end

endmodule

[hdl/first_fit_pool_allocator_lifo_cache.sv]
// ----------------------------------------------------------------------------
// first_fit_pool_allocator_lifo_cache
// Pool allocator: allocate, free and get over a block store in one RAM,
// with a LIFO cache of freed blocks and a first-fit free list.
// ----------------------------------------------------------------------------
// Allocate: a cache hit marks the cached block allocated; on a miss the free
//   list is walked first-fit, splitting the block found when enough remains.
// Throughput: one item at a time; the walk over the block store RAM (one
//   header read per visited block) sets the time of a free-list allocate.
// Reset and pool_bytes writes start a clearing pass over all 1024 entries of the
//   block store; no beat is accepted until it ends.
module first_fit_pool_allocator_lifo_cache
    import ffpa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [47:0]      s_tdata,  // request_bytes, block_offset, view_bytes
    input  logic [1:0]       s_tuser,  // cmd
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [71:0]      m_tdata,  // result_offset, result_length, from_cache,
                                       // live_blocks, zero fill
    output logic [1:0]       m_tuser   // status
);

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_CLEAR    = 16'h0002,
        S_DISPATCH = 16'h0004,
        S_WALK_RD  = 16'h0008,
        S_WALK_CHK = 16'h0010,
        S_SPLIT_RD = 16'h0020,
        S_SPLIT_WR = 16'h0040,
        S_PREV_RD  = 16'h0080,
        S_PREV_WR  = 16'h0100,
        S_CUR_RD   = 16'h0200,
        S_CUR_WR   = 16'h0400,
        S_FREE_RD  = 16'h0800,
        S_FREE_WR  = 16'h1000,
        S_MARK_RD  = 16'h2000,
        S_MARK_WR  = 16'h4000,
        S_DONE     = 16'h8000
    } state_t;

    state_t             state_reg, state_next;
    logic [UNIT_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [UNIT_W-1:0]  eff_reg, eff_next;
    logic [UNIT_W-1:0]  free_head_reg, free_head_next;
    logic [31:0]        total_reg, total_next;
    logic [1:0]         cmd_reg, cmd_next;
    logic [15:0]        req_reg, req_next;
    logic [15:0]        off_reg, off_next;
    logic [15:0]        view_reg, view_next;
    logic [UNIT_W-1:0]  need_reg, need_next;
    logic [UNIT_W-1:0]  cur_reg, cur_next;
    logic [UNIT_W-1:0]  prev_reg, prev_next;
    logic [UNIT_W-1:0]  nxt_reg, nxt_next;
    logic [UNIT_W-1:0]  rem_reg, rem_next;
    logic [UNIT_W-1:0]  steps_reg, steps_next;
    logic               split_reg, split_next;
    logic [1:0]         status_reg, status_next;
    logic [15:0]        roff_reg, roff_next;
    logic [15:0]        rlen_reg, rlen_next;
    logic               fc_reg, fc_next;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic [15:0]        m_roff_reg, m_roff_next;
    logic [15:0]        m_rlen_reg, m_rlen_next;
    logic               m_fc_reg, m_fc_next;
    logic [31:0]        m_live_reg, m_live_next;

    logic               mem_we;
    logic [UNIT_AW-1:0] mem_waddr;
    mem_word_t          mem_wdata;
    logic [UNIT_AW-1:0] mem_raddr;
    mem_word_t          mem_rdata;
    cache_ctrl_t        cache_ctrl;
    cache_stat_t        cache_stat;

    logic [UNIT_W-1:0]  need_c;
    logic [UNIT_W-1:0]  nb_c;
    logic [UNIT_W:0]    nb_sum;
    logic [UNIT_W-1:0]  link_c;
    logic [UNIT_W-1:0]  cfg_raw;
    logic [UNIT_W-1:0]  cfg_eff;
    logic [CFG_W-1:0]   pool_b;
    logic [CFG_W-1:0]   bytes_c;
    logic [CFG_W-1:0]   avail_c;
    logic [UNIT_W-1:0]  rem_c;
    logic [UNIT_W:0]    split_sum;
    mem_word_t          init_word;

    ffpa_ram #(
        .WIDTH ($bits(mem_word_t)),
        .DEPTH (POOL_UNITS)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ffpa_cache u_cache (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (cache_ctrl),
        .stat    (cache_stat)
    );

    // derived values
    assign need_c  = UNIT_W'((CFG_W'(HDR_BYTES) + CFG_W'(req_reg) + CFG_W'(UNIT_BYTES - 1))
                             >> UNIT_SHIFT);
    assign nb_sum  = {1'b0, cur_reg} + {1'b0, need_reg};
    assign nb_c    = nb_sum[UNIT_W-1:0];
    assign link_c  = split_reg ? nb_c : nxt_reg;
    assign cfg_raw = cfg_wr_data[CFG_W-1:UNIT_SHIFT];
    assign cfg_eff = (cfg_raw == '0) ? UNIT_W'(1)
                   : (cfg_raw > UNIT_W'(POOL_UNITS)) ? UNIT_W'(POOL_UNITS) : cfg_raw;
    assign pool_b  = CFG_W'({eff_reg, {UNIT_SHIFT{1'b0}}});
    assign bytes_c = CFG_W'({mem_rdata.units, {UNIT_SHIFT{1'b0}}});
    assign avail_c = (bytes_c >= CFG_W'(HDR_BYTES)) ? bytes_c - CFG_W'(HDR_BYTES) : '0;
    assign rem_c   = mem_rdata.units - need_reg;
    assign split_sum = {1'b0, cur_reg} + {1'b0, need_reg};

    always_comb begin
        init_word       = '0;
        init_word.hdr   = 1'b1;
        init_word.units = eff_reg;
        init_word.nxt   = NIL_UNIT;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {7'd0, m_live_reg, m_fc_reg, m_rlen_reg, m_roff_reg};

    // sequencer
    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        eff_next       = eff_reg;
        free_head_next = free_head_reg;
        total_next     = total_reg;
        cmd_next       = cmd_reg;
        req_next       = req_reg;
        off_next       = off_reg;
        view_next      = view_reg;
        need_next      = need_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        nxt_next       = nxt_reg;
        rem_next       = rem_reg;
        steps_next     = steps_reg;
        split_next     = split_reg;
        status_next    = status_reg;
        roff_next      = roff_reg;
        rlen_next      = rlen_reg;
        fc_next        = fc_reg;
        m_valid_next   = m_valid_reg;
        m_status_next  = m_status_reg;
        m_roff_next    = m_roff_reg;
        m_rlen_next    = m_rlen_reg;
        m_fc_next      = m_fc_reg;
        m_live_next    = m_live_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_reg[UNIT_AW-1:0];
        mem_wdata      = mem_rdata;
        mem_raddr      = cur_reg[UNIT_AW-1:0];
        cache_ctrl       = '0;
        cache_ctrl.need  = need_c;
        cache_ctrl.unit  = off_reg[UNIT_SHIFT +: UNIT_AW];
        cache_ctrl.size  = mem_rdata.units;

        // drop the output beat once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tuser;
                    req_next   = s_tdata[15:0];
                    off_next   = s_tdata[31:16];
                    view_next  = s_tdata[47:32];
                    state_next = S_DISPATCH;
                end
            end
            S_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = (clr_cnt_reg == '0) ? init_word : '0;
                clr_cnt_next = clr_cnt_reg + UNIT_AW'(1);
                if (clr_cnt_reg == UNIT_AW'(POOL_UNITS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_DISPATCH: begin
                status_next = ST_INVALID;
                roff_next   = '0;
                rlen_next   = '0;
                fc_next     = 1'b0;
                need_next   = need_c;
                if (cmd_reg == CMD_ALLOC) begin
                    if (need_c > eff_reg) begin
                        status_next = ST_TOO_LARGE;
                        state_next  = S_DONE;
                    end else if (cache_stat.hit) begin
                        cache_ctrl.take = 1'b1;
                        cur_next        = UNIT_W'(cache_stat.hit_unit);
                        state_next      = S_MARK_RD;
                    end else begin
                        status_next = ST_EXHAUSTED;
                        prev_next   = NIL_UNIT;
                        cur_next    = free_head_reg;
                        steps_next  = '0;
                        state_next  = (free_head_reg < eff_reg) ? S_WALK_RD : S_DONE;
                    end
                end else if (cmd_reg == CMD_FREE || cmd_reg == CMD_GET) begin
                    cur_next = UNIT_W'(off_reg[UNIT_SHIFT +: UNIT_AW]);
                    if (CFG_W'(off_reg) < pool_b && off_reg[UNIT_SHIFT-1:0] == '0) begin
                        state_next = S_FREE_RD;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    state_next = S_DONE;
                end
            end
            S_WALK_RD: begin
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                steps_next = steps_reg + UNIT_W'(1);
                if (mem_rdata.units >= need_reg) begin
                    rem_next   = rem_c;
                    nxt_next   = mem_rdata.nxt;
                    split_next = (rem_c >= UNIT_W'(2))
                               && (split_sum < (UNIT_W+1)'(POOL_UNITS));
                    if ((rem_c >= UNIT_W'(2)) && (split_sum < (UNIT_W+1)'(POOL_UNITS))) begin
                        state_next = S_SPLIT_RD;
                    end else if (prev_reg == NIL_UNIT) begin
                        free_head_next = mem_rdata.nxt;
                        state_next     = S_CUR_RD;
                    end else begin
                        state_next = S_PREV_RD;
                    end
                end else begin
                    prev_next = cur_reg;
                    cur_next  = mem_rdata.nxt;
                    if (mem_rdata.nxt < eff_reg && (steps_reg + UNIT_W'(1)) < eff_reg) begin
                        state_next = S_WALK_RD;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SPLIT_RD: begin
                mem_raddr  = nb_c[UNIT_AW-1:0];
                state_next = S_SPLIT_WR;
            end
            S_SPLIT_WR: begin
                mem_we          = 1'b1;
                mem_waddr       = nb_c[UNIT_AW-1:0];
                mem_wdata.hdr   = 1'b1;
                mem_wdata.units = rem_reg;
                mem_wdata.nxt   = nxt_reg;
                if (prev_reg == NIL_UNIT) begin
                    free_head_next = link_c;
                    state_next     = S_CUR_RD;
                end else begin
                    state_next = S_PREV_RD;
                end
            end
            S_PREV_RD: begin
                mem_raddr  = prev_reg[UNIT_AW-1:0];
                state_next = S_PREV_WR;
            end
            S_PREV_WR: begin
                mem_we        = 1'b1;
                mem_waddr     = prev_reg[UNIT_AW-1:0];
                mem_wdata.nxt = link_c;
                state_next    = S_CUR_RD;
            end
            S_CUR_RD: begin
                state_next = S_CUR_WR;
            end
            S_CUR_WR: begin
                mem_we          = 1'b1;
                mem_wdata.alloc = 1'b1;
                mem_wdata.nxt   = NIL_UNIT;
                if (split_reg) begin
                    mem_wdata.units = need_reg;
                end
                total_next  = total_reg + 32'd1;
                status_next = ST_OK;
                roff_next   = 16'({cur_reg[UNIT_AW-1:0], {UNIT_SHIFT{1'b0}}});
                rlen_next   = req_reg;
                state_next  = S_DONE;
            end
            S_MARK_RD: begin
                state_next = S_MARK_WR;
            end
            S_MARK_WR: begin
                mem_we          = 1'b1;
                mem_wdata.alloc = 1'b1;
                total_next  = total_reg + 32'd1;
                status_next = ST_OK;
                roff_next   = 16'({cur_reg[UNIT_AW-1:0], {UNIT_SHIFT{1'b0}}});
                rlen_next   = req_reg;
                fc_next     = 1'b1;
                state_next  = S_DONE;
            end
            S_FREE_RD: begin
                state_next = S_FREE_WR;
            end
            S_FREE_WR: begin
                state_next = S_DONE;
                if (mem_rdata.hdr) begin
                    if (cmd_reg == CMD_FREE) begin
                        mem_we          = 1'b1;
                        mem_wdata.alloc = 1'b0;
                        if (cache_stat.full) begin
                            mem_wdata.nxt  = free_head_reg;
                            free_head_next = cur_reg;
                        end else begin
                            cache_ctrl.put = 1'b1;
                        end
                        total_next  = total_reg - 32'd1;
                        status_next = ST_OK;
                    end else if (mem_rdata.alloc) begin
                        rlen_next   = (CFG_W'(view_reg) <= avail_c) ? view_reg
                                                                    : avail_c[15:0];
                        status_next = ST_OK;
                    end
                end
            end
            S_DONE: begin
                // load the output beat when the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_roff_next   = roff_reg;
                    m_rlen_next   = rlen_reg;
                    m_fc_next     = fc_reg;
                    m_live_next   = total_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // pool size write: restart the clearing pass
        if (cfg_wr_en) begin
            cache_ctrl.clear = 1'b1;
            cache_ctrl.take  = 1'b0;
            cache_ctrl.put   = 1'b0;
            eff_next         = cfg_eff;
            free_head_next   = '0;
            total_next       = '0;
            clr_cnt_next     = '0;
            state_next       = S_CLEAR;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            eff_reg       <= UNIT_W'(POOL_UNITS);
            free_head_reg <= '0;
            total_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            eff_reg       <= eff_next;
            free_head_reg <= free_head_next;
            total_reg     <= total_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        req_reg      <= req_next;
        off_reg      <= off_next;
        view_reg     <= view_next;
        need_reg     <= need_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        nxt_reg      <= nxt_next;
        rem_reg      <= rem_next;
        steps_reg    <= steps_next;
        split_reg    <= split_next;
        status_reg   <= status_next;
        roff_reg     <= roff_next;
        rlen_reg     <= rlen_next;
        fc_reg       <= fc_next;
        m_status_reg <= m_status_next;
        m_roff_reg   <= m_roff_next;
        m_rlen_reg   <= m_rlen_next;
        m_fc_reg     <= m_fc_next;
        m_live_reg   <= m_live_next;
    end

endmodule
